/* rtl/sblc_pkg.sv */
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared types and constants for the byte-budget LRU cache.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 21;
  localparam int STAMP_W  = 48;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 72;  // 69 payload bits, zero padded to whole bytes

  localparam logic [SIZE_W-1:0] BUDGET_RESET = SIZE_W'(32768);

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_EVICTED  = 3'd3,
    ST_REJECT   = 3'd4
  } status_t;

  // request kinds
  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_INSERT = 1'b1
  } req_t;

  // scan modes of the shared compare unit
  typedef enum logic {
    SCAN_KEY = 1'b0,
    SCAN_AGE = 1'b1
  } scan_mode_t;

  // one table slot as stored in the slot RAM
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic       start;
    scan_mode_t mode;
  } scan_ctrl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
    slot_t            slot;
  } scan_res_t;

endpackage

/* rtl/sblc_ram.sv */
// ----------------------------------------------------------------------------
// sblc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sblc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sblc_scan.sv */
// ----------------------------------------------------------------------------
// sblc_scan
// Slot scanner: walks the slot RAM one entry a cycle through one shared
// compare unit, finding either the first valid key match or the valid slot
// with the oldest stamp (lowest index wins a tie).
// ----------------------------------------------------------------------------
module sblc_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  sblc_pkg::scan_ctrl_t                ctrl,
  input  logic [sblc_pkg::KEY_W-1:0]          key,
  input  logic [sblc_pkg::ENTRIES-1:0]        slot_valid,
  output logic [sblc_pkg::IDX_W-1:0]          rd_addr,
  input  sblc_pkg::slot_t                     rd_data,
  output sblc_pkg::scan_res_t                 res
);

  logic                          busy;
  logic [sblc_pkg::IDX_W-1:0]    cnt;
  logic                          chk_valid;
  logic [sblc_pkg::IDX_W-1:0]    chk_idx;
  sblc_pkg::scan_mode_t          mode;
  logic [sblc_pkg::KEY_W-1:0]    key_q;
  logic                          done;
  logic                          found;
  logic [sblc_pkg::IDX_W-1:0]    best_idx;
  sblc_pkg::slot_t               best;
  logic                          take;

  assign rd_addr = cnt;

  // shared compare: key equality or stamp ordering
  always_comb begin
    take = 1'b0;
    if (chk_valid && slot_valid[chk_idx]) begin
      unique case (mode)
        sblc_pkg::SCAN_KEY: take = !found && (rd_data.key == key_q);
        sblc_pkg::SCAN_AGE: take = !found || (rd_data.stamp < best.stamp);
        default:            take = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
      found     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        found     <= 1'b0;
        chk_valid <= 1'b0;
      end else begin
        chk_valid <= busy;
        if (busy) begin
          chk_idx <= cnt;
          cnt     <= cnt + 1'b1;
          if (cnt == sblc_pkg::IDX_W'(sblc_pkg::ENTRIES - 1)) begin
            busy <= 1'b0;
          end
        end
        if (take) begin
          found <= 1'b1;
        end
        if (chk_valid && chk_idx == sblc_pkg::IDX_W'(sblc_pkg::ENTRIES - 1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode  <= ctrl.mode;
      key_q <= key;
    end
    if (take) begin
      best_idx <= chk_idx;
      best     <= rd_data;
    end
  end

  assign res.done  = done;
  assign res.found = found;
  assign res.idx   = best_idx;
  assign res.slot  = best;

endmodule

/* rtl/size_budget_lru_cache_top.sv */
// ----------------------------------------------------------------------------
// size_budget_lru_cache_top
// LRU cache of variable-size entries held under a byte budget.
// ----------------------------------------------------------------------------
// s_* takes one request word: tuser = kind (lookup/insert), tdata = key,
//   handle, size. m_* returns result words: tuser = status, tdata = key,
//   handle, bytes in use, tlast on the last word of a request. A lookup gives
//   one word; an insert one word per evicted entry, then the final word.
// Write cache_budget via cfg_wen/cfg_wdata only while idle; the block does not enforce this.
// Search: each table search walks the 16 slots through one compare unit,
//   one RAM read a cycle. An insert runs a key search, then per eviction a
//   check step, an age search and an emit, then a store and the final word.
//   A rejected insert goes straight to the final word.
//   s_tready is high only when no request is in progress.
// Reset (rst, synchronous): empties the table, zeroes use clock and byte
//   count, budget back to 32768; slot RAM contents are kept, only valid
//   slots are ever used.
// Stall: while the result register waits on m_tready the sequencer holds;
//   a new request may be taken while the final word still waits.
// ----------------------------------------------------------------------------
module size_budget_lru_cache_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_wen,
  input  logic [sblc_pkg::SIZE_W-1:0]          cfg_wdata,   // cache_budget
  // request stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sblc_pkg::DATA_W-1:0]          s_tdata,     // key, entry_handle, entry_size
  input  logic                                 s_tuser,     // req_type
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sblc_pkg::DATA_W-1:0]          m_tdata,     // out_key, out_handle, bytes_in_use
  output logic [sblc_pkg::STATUS_W-1:0]        m_tuser,     // status
  output logic                                 m_tlast      // last
);

  localparam int KW = sblc_pkg::KEY_W;
  localparam int HW = sblc_pkg::HANDLE_W;
  localparam int SW = sblc_pkg::SIZE_W;
  localparam int IW = sblc_pkg::IDX_W;
  localparam int N  = sblc_pkg::ENTRIES;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KEY   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_AGE   = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_STORE = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state, state_next;

  // request fields from the input word
  logic [KW-1:0] in_key;
  logic [HW-1:0] in_handle;
  logic [SW-1:0] in_size;

  assign in_key    = s_tdata[KW-1:0];
  assign in_handle = s_tdata[KW+HW-1:KW];
  assign in_size   = s_tdata[KW+HW+SW-1:KW+HW];

  // architectural state
  logic [SW-1:0]                 budget;
  logic [SW-1:0]                 used_bytes;
  logic [sblc_pkg::STAMP_W-1:0]  use_clock;
  logic [N-1:0]                  slot_valid;

  // latched request
  sblc_pkg::req_t req;
  logic [KW-1:0]  req_key;
  logic [HW-1:0]  req_handle;
  logic [SW-1:0]  req_size;

  // pending result
  sblc_pkg::status_t pend_status;
  logic [KW-1:0]     pend_key;
  logic [HW-1:0]     pend_handle;

  // output register
  sblc_pkg::status_t out_status;
  logic [KW-1:0]     out_key;
  logic [HW-1:0]     out_handle;
  logic [SW-1:0]     out_bytes;

  // scanner and slot RAM
  sblc_pkg::scan_ctrl_t  scan_ctrl;
  sblc_pkg::scan_res_t   scan_res;
  logic [IW-1:0]         rd_addr;
  sblc_pkg::slot_t       rd_data;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  sblc_pkg::slot_t       ram_wdata;

  logic          accept;
  logic          reject;
  logic          out_free;
  logic          all_valid;
  logic          any_valid;
  logic [IW-1:0] free_idx;
  logic          over_budget;
  logic          need_evict;
  logic [SW-1:0] used_minus_best;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign reject   = (sblc_pkg::req_t'(s_tuser) == sblc_pkg::REQ_INSERT) && (in_size > budget);
  assign out_free = !m_tvalid || m_tready;

  assign all_valid = &slot_valid;
  assign any_valid = |slot_valid;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign over_budget = ({1'b0, used_bytes} + {1'b0, req_size}) > {1'b0, budget};
  assign need_evict  = over_budget || all_valid;

  // saturating release of the slot the scanner picked
  assign used_minus_best = (used_bytes >= scan_res.slot.size) ?
                           used_bytes - scan_res.slot.size : '0;

  // scanner start
  always_comb begin
    scan_ctrl.start = 1'b0;
    scan_ctrl.mode  = sblc_pkg::SCAN_KEY;
    if (state == S_IDLE && accept && !reject) begin
      scan_ctrl.start = 1'b1;
    end else if (state == S_CHECK && need_evict && any_valid) begin
      scan_ctrl.start = 1'b1;
      scan_ctrl.mode  = sblc_pkg::SCAN_AGE;
    end
  end

  // slot RAM writes: stamp refresh on hit, new entry on store
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_res.idx;
    ram_wdata = scan_res.slot;
    ram_wdata.stamp = use_clock;
    if (state == S_KEY && scan_res.done && req == sblc_pkg::REQ_LOOKUP && scan_res.found) begin
      ram_we = 1'b1;
    end else if (state == S_STORE && !all_valid) begin
      ram_we           = 1'b1;
      ram_waddr        = free_idx;
      ram_wdata.key    = req_key;
      ram_wdata.handle = req_handle;
      ram_wdata.size   = req_size;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = reject ? S_FINAL : S_KEY;
        end
      end
      S_KEY: begin
        if (scan_res.done) begin
          state_next = (req == sblc_pkg::REQ_LOOKUP) ? S_FINAL : S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (need_evict && any_valid) ? S_AGE : S_STORE;
      end
      S_AGE: begin
        if (scan_res.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_CHECK;
        end
      end
      S_STORE: state_next = S_FINAL;
      S_FINAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      budget     <= sblc_pkg::BUDGET_RESET;
      used_bytes <= '0;
      use_clock  <= '0;
      slot_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        budget <= cfg_wdata;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_KEY: begin
          if (scan_res.done && scan_res.found) begin
            if (req == sblc_pkg::REQ_LOOKUP) begin
              use_clock <= use_clock + 1'b1;
            end else begin
              // same key on insert: drop old entry silently
              slot_valid[scan_res.idx] <= 1'b0;
              used_bytes               <= used_minus_best;
            end
          end
        end
        S_AGE: begin
          if (scan_res.done) begin
            slot_valid[scan_res.idx] <= 1'b0;
            used_bytes               <= used_minus_best;
          end
        end
        S_STORE: begin
          if (!all_valid) begin
            slot_valid[free_idx] <= 1'b1;
            use_clock            <= use_clock + 1'b1;
            used_bytes           <= used_bytes + req_size;
          end
        end
        S_EMIT, S_FINAL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= sblc_pkg::req_t'(s_tuser);
      req_key    <= in_key;
      req_handle <= in_handle;
      req_size   <= in_size;
      pend_key    <= in_key;
      pend_status <= sblc_pkg::ST_REJECT;
      pend_handle <= '0;
    end
    unique case (state)
      S_KEY: begin
        if (scan_res.done && req == sblc_pkg::REQ_LOOKUP) begin
          pend_status <= scan_res.found ? sblc_pkg::ST_HIT : sblc_pkg::ST_MISS;
          pend_handle <= scan_res.found ? scan_res.slot.handle : '0;
        end
      end
      S_AGE: begin
        if (scan_res.done) begin
          pend_status <= sblc_pkg::ST_EVICTED;
          pend_key    <= scan_res.slot.key;
          pend_handle <= scan_res.slot.handle;
        end
      end
      S_STORE: begin
        pend_status <= sblc_pkg::ST_INSERTED;
        pend_key    <= req_key;
        pend_handle <= req_handle;
      end
      S_EMIT, S_FINAL: begin
        if (out_free) begin
          out_status <= pend_status;
          out_key    <= pend_key;
          out_handle <= pend_handle;
          out_bytes  <= used_bytes;
          m_tlast    <= (state == S_FINAL);
        end
      end
      default: ;
    endcase
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(sblc_pkg::DATA_W - KW - HW - SW){1'b0}}, out_bytes, out_handle, out_key};

  sblc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (scan_ctrl),
    .key        (in_key),
    .slot_valid (slot_valid),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (scan_res)
  );

  sblc_ram #(
    .WIDTH (sblc_pkg::SLOT_W),
    .DEPTH (N)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-budget LRU cache.
// ----------------------------------------------------------------------------
// Drives lookup and insert words into the request stream and scores every
// result word against a behavioral model of the table. The model tracks the
// slots, the use clock, the byte count and the budget. The run covers
// directed corner cases, a back-pressure fill, and random traffic under
// several budgets and idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sblc_pkg::*;

  localparam int CLK_HALF     = 6;       // 12 ns period
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 40;      // longer than one full search + handoff
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;
  localparam logic [SIZE_W-1:0] BUDGET_MAX = SIZE_W'(1048576);

  // expected result word
  typedef struct {
    status_t             status;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   bytes;
    logic                last;
  } cache_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [SIZE_W-1:0]    cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata   = '0;   // key, entry_handle, entry_size
  logic                 s_tuser   = 1'b0; // req_type
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DATA_W-1:0]    m_tdata;          // out_key, out_handle, bytes_in_use
  logic [STATUS_W-1:0]  m_tuser;          // status
  logic                 m_tlast;

  size_budget_lru_cache_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the cache table
  // --------------------------------------------------------------------------
  logic                tbl_valid  [ENTRIES];
  logic [KEY_W-1:0]    tbl_key    [ENTRIES];
  logic [HANDLE_W-1:0] tbl_handle [ENTRIES];
  logic [SIZE_W-1:0]   tbl_size   [ENTRIES];
  logic [STAMP_W-1:0]  tbl_stamp  [ENTRIES];
  logic [STAMP_W-1:0]  model_clock  = '0;
  logic [SIZE_W-1:0]   model_used   = '0;
  logic [SIZE_W-1:0]   model_budget = BUDGET_RESET;

  cache_result_t pending_results[$];   // oldest first

  // idle mix and hold-off knobs, set by the tests
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned snk_hold     = 0;       // cycles left of a forced sink stall

  // bookkeeping
  int unsigned error_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned req_count      = 0;
  int unsigned result_count   = 0;
  int unsigned evict_count    = 0;
  int unsigned budget_writes  = 0;
  int unsigned cycle_count    = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  function automatic int slot_of_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < ENTRIES; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  // oldest stamp, lowest index on a tie
  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && (best < 0 || tbl_stamp[i] < tbl_stamp[best])) best = i;
    return best;
  endfunction

  function automatic void queue_result(status_t st, logic [KEY_W-1:0] k,
                                       logic [HANDLE_W-1:0] h, logic lst);
    cache_result_t r;
    r.status = st;
    r.key    = k;
    r.handle = h;
    r.bytes  = model_used;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_slot(int s);
    tbl_valid[s] = 1'b0;
    model_used   = (model_used >= tbl_size[s]) ? model_used - tbl_size[s] : '0;
  endfunction

  // Works out every result word one accepted request causes.
  function automatic void predict_cache_request(req_t req, logic [KEY_W-1:0] k,
                                                logic [HANDLE_W-1:0] h,
                                                logic [SIZE_W-1:0] sz);
    int s;
    int v;
    if (req == REQ_LOOKUP) begin
      s = slot_of_key(k);
      if (s >= 0) begin
        tbl_stamp[s] = model_clock;
        model_clock  = model_clock + 1'b1;
        queue_result(ST_HIT, k, tbl_handle[s], 1'b1);
      end else begin
        queue_result(ST_MISS, k, '0, 1'b1);
      end
      return;
    end
    if (sz > model_budget) begin
      queue_result(ST_REJECT, k, '0, 1'b1);
      return;
    end
    // same key: old entry goes away without a report
    s = slot_of_key(k);
    if (s >= 0) drop_slot(s);
    while ((({1'b0, model_used} + {1'b0, sz}) > {1'b0, model_budget}) ||
           free_slot() < 0) begin
      v = oldest_slot();
      if (v < 0) break;
      drop_slot(v);
      queue_result(ST_EVICTED, tbl_key[v], tbl_handle[v], 1'b0);
    end
    s = free_slot();
    if (s >= 0) begin
      tbl_valid[s]  = 1'b1;
      tbl_key[s]    = k;
      tbl_handle[s] = h;
      tbl_size[s]   = sz;
      tbl_stamp[s]  = model_clock;
      model_clock   = model_clock + 1'b1;
      model_used    = model_used + sz;
    end
    queue_result(ST_INSERTED, k, h, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: score each accepted word, then pick next tready.
  // Values read here are the ones before the edge, since all drivers are NBA.
  // --------------------------------------------------------------------------
  task automatic score_result_word();
    cache_result_t exp_r;
    logic [KEY_W-1:0]    got_key;
    logic [HANDLE_W-1:0] got_handle;
    logic [SIZE_W-1:0]   got_bytes;
    got_key    = m_tdata[KEY_W-1:0];
    got_handle = m_tdata[KEY_W +: HANDLE_W];
    got_bytes  = m_tdata[KEY_W+HANDLE_W +: SIZE_W];
    result_count++;
    if (pending_results.size() == 0) begin
      error_count++;
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("[%0t] unexpected result word: st=%0d key=%h hdl=%h bytes=%0d last=%0b",
                 $realtime, m_tuser, got_key, got_handle, got_bytes, m_tlast);
      return;
    end
    exp_r = pending_results.pop_front();
    if (exp_r.status == ST_EVICTED) evict_count++;
    if (m_tuser !== exp_r.status || got_key !== exp_r.key ||
        got_handle !== exp_r.handle || got_bytes !== exp_r.bytes ||
        m_tlast !== exp_r.last) begin
      error_count++;
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  exp st=%0d key=%h hdl=%h bytes=%0d last=%0b",
                 exp_r.status, exp_r.key, exp_r.handle, exp_r.bytes, exp_r.last);
        $display("  got st=%0d key=%h hdl=%h bytes=%0d last=%0b",
                 m_tuser, got_key, got_handle, got_bytes, m_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (m_tvalid && m_tready) score_result_word();
    // forced hold-off wins over the random idle mix
    if (snk_hold != 0) begin
      snk_hold = snk_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------
  // Offers one request word; returns right after the accepting edge with
  // tvalid still high, so a back-to-back word never toggles it in one step.
  task automatic send_request(req_t req, logic [KEY_W-1:0] k,
                              logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(DATA_W-KEY_W-HANDLE_W-SIZE_W){1'b0}}, sz, h, k};
    do @(posedge clk); while (!s_tready);
    predict_cache_request(req, k, h, sz);
    req_count++;
  endtask

  task automatic stop_requests();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // waits until every expected word is in, then covers the block's latency
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_budget(logic [SIZE_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    model_budget = value;
    budget_writes++;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Default budget: miss on empty table, too-large reject, exact-fit insert,
  // zero-size insert alongside it, hit with extreme key and handle.
  task automatic test_reset_budget_edges();
    send_request(REQ_LOOKUP, 32'h0000_0000, 16'hFFFF, BUDGET_MAX);
    send_request(REQ_INSERT, 32'h1234_5678, 16'hA5A5, BUDGET_RESET + 1'b1);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, BUDGET_RESET);
    send_request(REQ_INSERT, 32'h0000_0000, 16'h0000, '0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0000, '0);
    stop_requests();
    wait_drained();
  endtask

  // Fill every slot under the max budget, refresh an older entry by a hit and
  // check that the next insert evicts by table fullness in stamp order.
  task automatic test_table_full_eviction();
    write_budget(BUDGET_MAX);
    for (int i = 1; i <= ENTRIES - 2; i++)
      send_request(REQ_INSERT, KEY_W'(i), HANDLE_W'(16'h0100 + i), SIZE_W'(100 + 7 * i));
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_request(REQ_INSERT, 32'h0000_0100, 16'h5A5A, SIZE_W'(4096));
    stop_requests();
    wait_drained();
  endtask

  // Same-key replace, then budget dropped to zero: the next insert evicts
  // the whole table (max result count); a nonzero size is then rejected.
  task automatic test_replace_and_budget_drop();
    send_request(REQ_INSERT, 32'h0000_0005, 16'hBEEF, SIZE_W'(50000));
    stop_requests();
    wait_drained();
    write_budget('0);
    send_request(REQ_INSERT, 32'hCAFE_0001, 16'h0001, '0);
    send_request(REQ_INSERT, 32'hCAFE_0002, 16'h0002, SIZE_W'(1));
    send_request(REQ_LOOKUP, 32'h0000_0005, '0, '0);
    stop_requests();
    wait_drained();
  endtask

  // Long sink hold-off while requests keep coming, so the block backs up and
  // stalls its input; then the sender pauses until everything has drained.
  task automatic test_backpressure_fill();
    write_budget(SIZE_W'(16384));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    snk_hold     = 400;
    for (int i = 0; i < 8; i++)
      send_request((i % 3 == 2) ? REQ_LOOKUP : REQ_INSERT, KEY_W'(32'h0BAD_0000 + (i % 5)),
                   HANDLE_W'($urandom), SIZE_W'($urandom_range(1, 6000)));
    stop_requests();
    wait_drained();
    for (int i = 0; i < 4; i++)
      send_request(REQ_LOOKUP, KEY_W'(32'h0BAD_0000 + i), '0, '0);
    stop_requests();
    wait_drained();
  endtask

  // Random traffic over a small key pool so hits, replaces and evictions
  // are common; a few keys are fully random and sizes run from 0 to 1048576.
  task automatic test_random_traffic(int n, int unsigned src_pct, int unsigned snk_pct,
                                     logic [SIZE_W-1:0] budget);
    logic [KEY_W-1:0]    pool [20];
    logic [KEY_W-1:0]    k;
    logic [SIZE_W-1:0]   sz;
    logic [SIZE_W:0]     quarter;
    req_t                req;
    write_budget(budget);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    foreach (pool[i]) pool[i] = $urandom;
    quarter = {1'b0, budget} / 4 + 1;
    for (int i = 0; i < n; i++) begin
      req = ($urandom_range(99) < 45) ? REQ_LOOKUP : REQ_INSERT;
      k   = ($urandom_range(9) == 0) ? KEY_W'($urandom) : pool[$urandom_range(19)];
      case ($urandom_range(9))
        0:       sz = '0;
        1:       sz = budget;
        2:       sz = (budget < BUDGET_MAX) ? budget + 1'b1 : BUDGET_MAX;
        3:       sz = SIZE_W'($urandom_range(0, 1048576));
        default: sz = SIZE_W'($urandom_range(1, quarter));
      endcase
      send_request(req, k, HANDLE_W'($urandom), sz);
    end
    stop_requests();
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling on the request side
    src_idle_pct = 0;
    snk_idle_pct = 20;
    test_reset_budget_edges();
    test_table_full_eviction();
    test_replace_and_budget_drop();
    test_backpressure_fill();

    // random part: sender-light, sink-heavy; then swapped; then none
    test_random_traffic(22, 25, 63, SIZE_W'(4096));
    test_random_traffic(22, 63, 25, BUDGET_MAX);
    test_random_traffic(22, 0, 0, SIZE_W'($urandom_range(2048, 200000)));

    wait_drained();
    error_count += pending_results.size();

    $display("covered %0d requests, %0d result words (%0d evictions), %0d budget writes",
             req_count, result_count, evict_count, budget_writes);
    $display("mix: corner sizes, full-table and zero-budget flushes, sink hold-off, idle mixes");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
